### src/unsigned_divide_128_by_64_assert.svh
// Assertion macros for the unsigned 128-by-64 divider.
// Used by the top level. The clock clk_i and reset rst_ni must be in scope.
`ifndef UNSIGNED_DIVIDE_128_BY_64_ASSERT_SVH
`define UNSIGNED_DIVIDE_128_BY_64_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge out of reset
`define UDIV_ASSERT(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("udiv assertion failed");
// Check that a consequent holds whenever an antecedent holds, same edge
`define UDIV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("udiv assertion failed");
// Check that a consequent holds at the edge after an antecedent
`define UDIV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("udiv assertion failed");
`else
`define UDIV_ASSERT(label, expr)
`define UDIV_ASSERT_IMP(label, ante, cons)
`define UDIV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/udiv_pkg.sv
// Shared types and constants for the unsigned 128-by-64 divider.
// No dependencies; used by every other file but the assertion header.
`default_nettype none

package udiv_pkg;

  // Width of one word; the dividend is two words
  localparam int unsigned WordWidth = 64;
  localparam int unsigned NumWidth  = 2 * WordWidth;
  // One cell per dividend bit
  localparam int unsigned NumCells  = NumWidth;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [NumWidth-1:0]  dword_t;

  // Control that travels with a word down the cell chain
  typedef struct packed {
    logic valid;
    logic overflow;
    logic div_zero;
  } ctrl_t;

  // Working data of one word: partial remainder, dividend bits still to
  // shift out (quotient bits fill in from the bottom), and the divisor
  typedef struct packed {
    word_t  rem;
    dword_t num;
    word_t  div;
  } data_t;

endpackage

`default_nettype wire

### src/udiv_req_if.sv
// Request channel of the divider: valid/ready handshake with the operands.
// Depends on udiv_pkg.
`default_nettype none

interface udiv_req_if;
  logic            valid;
  logic            ready;
  udiv_pkg::word_t dividend_high;
  udiv_pkg::word_t dividend_low;
  udiv_pkg::word_t divisor;

  modport source (output valid, output dividend_high, output dividend_low,
                  output divisor, input ready);
  modport sink (input valid, input dividend_high, input dividend_low,
                input divisor, output ready);
endinterface

`default_nettype wire

### src/udiv_rsp_if.sv
// Response channel of the divider: valid/ready handshake with the results.
// Depends on udiv_pkg.
`default_nettype none

interface udiv_rsp_if;
  logic            valid;
  logic            ready;
  udiv_pkg::word_t quotient;
  udiv_pkg::word_t remainder;
  logic            quotient_overflow;
  logic            divide_by_zero;

  modport source (output valid, output quotient, output remainder,
                  output quotient_overflow, output divide_by_zero, input ready);
  modport sink (input valid, input quotient, input remainder,
                input quotient_overflow, input divide_by_zero, output ready);
endinterface

`default_nettype wire

### src/udiv_cell.sv
// One restoring division step: shift in a dividend bit, trial subtract,
// record the quotient bit. Depends on udiv_pkg.
`default_nettype none

module udiv_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire udiv_pkg::ctrl_t ctrl_i,
  input  wire udiv_pkg::data_t data_i,
  output udiv_pkg::ctrl_t      ctrl_o,
  output udiv_pkg::data_t      data_o
);

  localparam int unsigned W  = udiv_pkg::WordWidth;
  localparam int unsigned NW = udiv_pkg::NumWidth;

  udiv_pkg::ctrl_t ctrl_q;
  udiv_pkg::data_t data_q, data_d;
  logic            carry;
  udiv_pkg::word_t shifted;
  logic            take;

  // Shift the next dividend bit into the remainder and trial subtract
  always_comb begin
    carry       = data_i.rem[W-1];
    shifted     = {data_i.rem[W-2:0], data_i.num[NW-1]};
    take        = carry || (shifted >= data_i.div);
    data_d.rem  = take ? (shifted - data_i.div) : shifted;
    data_d.num  = {data_i.num[NW-2:0], take};
    data_d.div  = data_i.div;
  end

  // Clear control under reset, advance with the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // Advance the working data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

### src/udiv_out_stage.sv
// Output register of the divider: takes the last cell's word, zeroes the
// results on divide by zero and holds them while the receiver stalls.
// Depends on udiv_pkg and udiv_rsp_if.
`default_nettype none

module udiv_out_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire udiv_pkg::ctrl_t ctrl_i,
  input  wire udiv_pkg::data_t data_i,
  output logic                 en_o,
  udiv_rsp_if.source           rsp_o
);

  localparam int unsigned W = udiv_pkg::WordWidth;

  logic            valid_q;
  logic            ovf_q;
  logic            dz_q;
  udiv_pkg::word_t quo_q, quo_d;
  udiv_pkg::word_t rem_q, rem_d;

  // Advance the chain when the output register is free or being drained
  assign en_o = !valid_q || rsp_o.ready;

  // Drop the results to zero on divide by zero
  always_comb begin
    quo_d = ctrl_i.div_zero ? '0 : data_i.num[W-1:0];
    rem_d = ctrl_i.div_zero ? '0 : data_i.rem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      ovf_q <= ctrl_i.overflow;
      dz_q  <= ctrl_i.div_zero;
    end
  end

  assign rsp_o.valid             = valid_q;
  assign rsp_o.quotient          = quo_q;
  assign rsp_o.remainder         = rem_q;
  assign rsp_o.quotient_overflow = ovf_q;
  assign rsp_o.divide_by_zero    = dz_q;

endmodule

`default_nettype wire

### src/unsigned_divide_128_by_64.sv
// Unsigned 128-by-64 divider: top level with the chain of division cells.
// Depends on udiv_pkg, udiv_req_if, udiv_rsp_if, udiv_cell, udiv_out_stage
// and the assertion header.
//
// Usage:
//   req_i carries one word per division: dividend_high, dividend_low and
//   divisor. rsp_o returns quotient (low 64 bits of the full quotient),
//   remainder, quotient_overflow (dividend_high >= divisor) and
//   divide_by_zero (divisor zero; quotient and remainder then read zero).
//   Words are accepted on a rising edge with valid and ready both high.
//   Path: a word accepted at an edge enters the first of 128 cells, one
//   per dividend bit, each a 64-bit trial subtract; it passes down the
//   chain and through the output register before it shows on rsp_o.
//   Throughput: one word per cycle unless stalled; chain depth 129 words.
//   Stall: while the output register holds a word that is not taken, the
//   whole chain freezes and req_i.ready drops; it rises again in the cycle
//   the receiver takes the word. Bubbles stay in the chain.
//   Reset: asynchronous, active low; clears every valid bit, so no word
//   is in flight afterwards. No other state is kept between words.
`default_nettype none

`include "unsigned_divide_128_by_64_assert.svh"

module unsigned_divide_128_by_64 (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  udiv_req_if.sink   req_i,
  udiv_rsp_if.source rsp_o
);

  localparam int unsigned NC = udiv_pkg::NumCells;

  logic            en;
  udiv_pkg::ctrl_t ctrl  [NC+1];
  udiv_pkg::data_t data  [NC+1];

  // Feed the head of the chain from the request word
  assign ctrl[0].valid    = req_i.valid;
  assign ctrl[0].overflow = req_i.dividend_high >= req_i.divisor;
  assign ctrl[0].div_zero = req_i.divisor == '0;
  assign data[0].rem      = '0;
  assign data[0].num      = {req_i.dividend_high, req_i.dividend_low};
  assign data[0].div      = req_i.divisor;

  assign req_i.ready = en;

  // One cell per dividend bit, most significant first
  for (genvar gi = 0; gi < NC; gi++) begin : g_cell
    udiv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl[gi]),
      .data_i (data[gi]),
      .ctrl_o (ctrl[gi+1]),
      .data_o (data[gi+1])
    );
  end

  udiv_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl[NC]),
    .data_i (data[NC]),
    .en_o   (en),
    .rsp_o  (rsp_o)
  );

  // A finished remainder is always below a nonzero divisor
  `UDIV_ASSERT_IMP(a_rem_below_div, ctrl[NC].valid && !ctrl[NC].div_zero,
    data[NC].rem < data[NC].div)
  // An accepted word enters the first cell
  `UDIV_ASSERT_NEXT(a_accept_enters, req_i.valid && req_i.ready, ctrl[1].valid)
  // Divide by zero reads as zero results with overflow set
  `UDIV_ASSERT_IMP(a_div_zero_out, rsp_o.valid && rsp_o.divide_by_zero,
    rsp_o.quotient == '0 && rsp_o.remainder == '0 && rsp_o.quotient_overflow)
  // A stalled output keeps the chain frozen
  `UDIV_ASSERT_IMP(a_stall_freezes, rsp_o.valid && !rsp_o.ready, !en)

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the unsigned 128-by-64 divider pipeline.
// Depends on udiv_pkg, udiv_req_if, udiv_rsp_if and unsigned_divide_128_by_64.
// Predicts each quotient, remainder and flag pair and checks results in order.
`default_nettype none

module tb_top;

  typedef udiv_pkg::word_t  word_t;
  typedef udiv_pkg::dword_t dword_t;

  localparam int unsigned WordWidth      = udiv_pkg::WordWidth;
  localparam int unsigned MAX_GAP        = 6;
  localparam int unsigned LATENCY        = 130;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam word_t       WORD_MAX       = '1;
  localparam word_t       WORD_MSB       = word_t'(1) << (WordWidth - 1);

  // Expected contents of one result word
  typedef struct packed {
    word_t quotient;
    word_t remainder;
    logic  overflow;
    logic  div_zero;
  } quot_rem_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  udiv_req_if req_if ();
  udiv_rsp_if rsp_if ();

  unsigned_divide_128_by_64 u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  quot_rem_t   pending_quot[$];
  int unsigned fail_count    = 0;
  int unsigned words_checked = 0;
  int unsigned zero_div_seen = 0;
  int unsigned truncated     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned stall_bursts  = 0;
  bit          req_idle_en;
  bit          rsp_idle_en;
  int unsigned rsp_hold_req;

  always #2 clk_i = ~clk_i;

  // Divide the two-word dividend; keep the low word of the quotient
  function automatic quot_rem_t divide_words(word_t high, word_t low, word_t div);
    quot_rem_t res;
    dword_t    num;
    dword_t    quo;
    res.overflow  = (high >= div);
    res.div_zero  = (div == '0);
    res.quotient  = '0;
    res.remainder = '0;
    if (div != '0) begin
      num           = {high, low};
      quo           = num / dword_t'(div);
      res.quotient  = quo[WordWidth-1:0];
      res.remainder = word_t'(num % dword_t'(div));
    end
    return res;
  endfunction

  function automatic void log_error(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Check result words in order, record accepted requests, run the watchdog
  always @(posedge clk_i) begin : monitor
    quot_rem_t want;
    quot_rem_t got;
    logic      req_fire;
    logic      rsp_fire;
    if (rst_ni === 1'b1) begin
      req_fire = req_if.valid && req_if.ready;
      rsp_fire = rsp_if.valid && rsp_if.ready;
      if (rsp_fire) begin
        got = '{rsp_if.quotient, rsp_if.remainder, rsp_if.quotient_overflow,
                rsp_if.divide_by_zero};
        if (pending_quot.size() == 0) begin
          log_error($sformatf("result word with nothing pending: q=%h r=%h ovf=%b dz=%b",
                              got.quotient, got.remainder, got.overflow, got.div_zero));
        end else begin
          want = pending_quot.pop_front();
          words_checked++;
          if (got.quotient !== want.quotient || got.remainder !== want.remainder ||
              got.overflow !== want.overflow || got.div_zero !== want.div_zero) begin
            log_error($sformatf({"mismatch on word %0d: expected q=%h r=%h ovf=%b dz=%b,",
                                 " got q=%h r=%h ovf=%b dz=%b"}, words_checked,
                                want.quotient, want.remainder, want.overflow,
                                want.div_zero, got.quotient, got.remainder,
                                got.overflow, got.div_zero));
          end
        end
      end
      if (req_fire) begin
        want = divide_words(req_if.dividend_high, req_if.dividend_low, req_if.divisor);
        pending_quot.push_back(want);
        if (want.div_zero) zero_div_seen++;
        else if (want.overflow) truncated++;
      end
      // Stop a hung run
      if (req_fire || rsp_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles with no word moving", idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Drive rsp ready: random gaps per word, and a long hold when requested
  initial begin : receiver
    int unsigned wait_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    wait_left    = 0;
    hold_left    = 0;
    hold_seen    = 0;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_seen != rsp_hold_req) begin
        hold_seen    = rsp_hold_req;
        hold_left    = HOLD_CYCLES;
        stall_bursts++;
        rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        if (hold_left == 0) rsp_if.ready <= 1'b1;
      end else if (rsp_if.ready) begin
        if (rsp_if.valid) begin
          wait_left = rsp_idle_en ? $urandom_range(0, MAX_GAP) : 0;
          if (wait_left != 0) rsp_if.ready <= 1'b0;
        end
      end else if (wait_left <= 1) begin
        wait_left    = 0;
        rsp_if.ready <= 1'b1;
      end else begin
        wait_left--;
      end
    end
  end

  // Offer one request word and hold it until taken
  task automatic send_word(input word_t high, input word_t low, input word_t div);
    int unsigned gap;
    gap = req_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.dividend_high <= high;
    req_if.dividend_low  <= low;
    req_if.divisor       <= div;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  // Drop valid and wait for every pending result
  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (pending_quot.size() != 0) @(posedge clk_i);
  endtask

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t draw_divisor();
    case ($urandom_range(0, 19)) inside
      0:       return '0;
      [1:2]:   return word_t'($urandom_range(1, 255));
      3:       return word_t'(1) << $urandom_range(0, WordWidth - 1);
      4:       return WORD_MAX - word_t'($urandom_range(0, 15));
      [5:6]:   return rand_word() >> $urandom_range(1, WordWidth - 2);
      7:       return rand_word() | WORD_MSB;
      default: return rand_word();
    endcase
  endfunction

  // Mostly keep the high word below the divisor so the quotient fits
  function automatic word_t draw_high(word_t div);
    case ($urandom_range(0, 9)) inside
      [0:4]:   return (div == '0) ? rand_word() : rand_word() % div;
      5:       return div - word_t'($urandom_range(0, 1));
      6:       return div + word_t'($urandom_range(0, 3));
      7:       return '0;
      default: return rand_word();
    endcase
  endfunction

  function automatic word_t draw_low();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WORD_MAX;
      default: return rand_word();
    endcase
  endfunction

  task automatic send_random_word();
    word_t div;
    div = draw_divisor();
    send_word(draw_high(div), draw_low(), div);
  endtask

  // Field extremes, flag boundaries and divide by zero
  task automatic test_directed();
    req_idle_en = 1'b1;
    rsp_idle_en <= 1'b1;
    send_word('0, '0, word_t'(1));
    send_word('0, WORD_MAX, word_t'(1));
    send_word('0, WORD_MAX, word_t'(2));
    send_word(WORD_MAX, WORD_MAX, WORD_MAX);
    send_word(WORD_MAX - 1, WORD_MAX, WORD_MAX);
    send_word('0, word_t'(5), word_t'(7));
    send_word(word_t'(5), '0, word_t'(5));
    send_word(word_t'(4), WORD_MAX, word_t'(5));
    send_word(WORD_MSB - 1, WORD_MAX, WORD_MSB);
    send_word(WORD_MAX, '0, WORD_MSB);
    send_word(word_t'(1), '0, word_t'(1));
    send_word(word_t'(3), 64'h0123_4567_89ab_cdef, word_t'(16));
    send_word(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaab);
    send_word(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
    send_word('0, '0, '0);
    send_word(WORD_MAX, WORD_MAX, '0);
    send_word(WORD_MSB, word_t'(1), '0);
    wait_results_drained();
  endtask

  // Random words with random gaps on both sides
  task automatic test_random_gaps(input int unsigned count);
    req_idle_en = 1'b1;
    rsp_idle_en <= 1'b1;
    repeat (count) send_random_word();
    wait_results_drained();
  endtask

  // Full rate: no gaps on either side
  task automatic test_back_to_back(input int unsigned count);
    req_idle_en = 1'b0;
    rsp_idle_en <= 1'b0;
    repeat (count) send_random_word();
    wait_results_drained();
  endtask

  // Hold off the receiver while requests keep coming, so the chain fills
  task automatic test_output_stall(input int unsigned count);
    req_idle_en = 1'b0;
    rsp_idle_en <= 1'b1;
    rsp_hold_req <= rsp_hold_req + 1;
    repeat (count) send_random_word();
    wait_results_drained();
  endtask

  // Switch idling on and off in stretches
  task automatic test_idle_toggle(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        req_idle_en = 1'($urandom_range(0, 1));
        rsp_idle_en <= 1'($urandom_range(0, 1));
      end
      send_random_word();
    end
    wait_results_drained();
  endtask

  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.dividend_high = '0;
    req_if.dividend_low  = '0;
    req_if.divisor       = '0;
    req_idle_en          = 1'b1;
    rsp_idle_en          = 1'b1;
    rsp_hold_req         = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_gaps(700);
    test_back_to_back(400);
    test_output_stall(300);
    test_idle_toggle(400);

    // Let any stray result word show up
    repeat (2 * LATENCY) @(posedge clk_i);
    if (pending_quot.size() != 0) begin
      log_error($sformatf("%0d result words never arrived", pending_quot.size()));
    end

    $display("Checked %0d divisions: %0d by zero, %0d with truncated quotient,",
             words_checked, zero_div_seen, truncated);
    $display("  %0d long output stall(s), %0d error(s)", stall_bursts, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
